[hdl/xps_pkg.sv]
// shared constants, command and status types and the xorshift step for the playlist shuffler
`default_nettype none
package xps_pkg;

   // store depth and derived widths
   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;

   // fixed field widths
   localparam int SEED_W  = 16;
   localparam int CSR_W   = 7;
   localparam int FIELD_W = 6;
   localparam int RSP_W   = 16;

   // xorshift shift amounts
   localparam int XS_SHL_A = 5;
   localparam int XS_SHR_B = 9;
   localparam int XS_SHL_C = 2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;
      logic fill;
      logic advance;
      logic swap_read;
      logic write_n;
      logic write_i;
      logic out_read;
      logic out_next;
   } xps_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic div_busy;
   } xps_status_type;

   // one xorshift step, wrapping at 16 bits
   function automatic logic [SEED_W-1:0] xs_advance(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] y;
      y = x ^ (x << XS_SHL_A);
      y = y ^ (y >> XS_SHR_B);
      y = y ^ (y << XS_SHL_C);
      return y;
   endfunction

endpackage
`default_nettype wire

[hdl/xps_divider.sv]
// iterative restoring remainder unit, one dividend bit per cycle
`default_nettype none
module xps_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [xps_pkg::SEED_W-1:0] dividend,
   input  wire logic [xps_pkg::CNT_W-1:0]  divisor,
   output logic                            busy,
   output logic [xps_pkg::CNT_W-1:0]       remainder
);
   import xps_pkg::*;

   localparam int STEP_W = $clog2(SEED_W);

   logic [SEED_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    trial;

   // shift in the next dividend bit and subtract where it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[SEED_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SEED_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

[hdl/xps_datapath.sv]
// permutation store, generator, counters and output word for the shuffler
`default_nettype none
module xps_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire xps_pkg::xps_cmd_type        cmd,
   output xps_pkg::xps_status_type          status,
   input  wire logic                        csr_write,
   input  wire logic [xps_pkg::CSR_W-1:0]   csr_value,
   input  wire logic [xps_pkg::SEED_W-1:0]  seed,
   output logic [xps_pkg::FIELD_W-1:0]      position,
   output logic [xps_pkg::FIELD_W-1:0]      entry_value
);
   import xps_pkg::*;

   logic [CSR_W-1:0]  entry_count_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SEED_W-1:0] gen_ff, gen_in;
   logic [SEED_W-1:0] gen_next;
   logic [CNT_W-1:0]  count_sat;
   logic              idx_last;

   logic [IDX_W-1:0]  mem [MAX_ENTRIES];
   logic [IDX_W-1:0]  rd_n_ff, rd_i_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, wr_data;
   logic [IDX_W-1:0]  swap_idx;
   logic [CNT_W-1:0]  remainder;
   logic              div_busy;

   // count saturates at the store depth
   always_comb begin
      if ({1'b0, entry_count_ff} > (CSR_W + 1)'(MAX_ENTRIES)) begin
         count_sat = CNT_W'(MAX_ENTRIES);
      end else begin
         count_sat = CNT_W'(entry_count_ff);
      end
   end

   assign idx_last = (CNT_W'({1'b0, idx_ff}) + 1'b1) == count_ff;
   assign gen_next = xs_advance(gen_ff);
   assign swap_idx = remainder[IDX_W-1:0];

   // counter, generator and latched count
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      gen_in   = gen_ff;
      if (cmd.start) begin
         count_in = count_sat;
         idx_in   = '0;
         gen_in   = seed;
      end
      if (cmd.advance) begin
         gen_in = gen_next;
      end
      if (cmd.fill || cmd.write_i || cmd.out_next) begin
         idx_in = idx_last ? '0 : idx_ff + 1'b1;
      end
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= CSR_W'(MAX_ENTRIES);
         count_ff       <= '0;
         idx_ff         <= '0;
         gen_ff         <= '0;
      end else begin
         if (csr_write) begin
            entry_count_ff <= csr_value;
         end
         count_ff <= count_in;
         idx_ff   <= idx_in;
         gen_ff   <= gen_in;
      end
   end

   // remainder of the new generator value by the count
   xps_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.advance),
      .dividend  (gen_next),
      .divisor   (count_ff),
      .busy      (div_busy),
      .remainder (remainder)
   );

   // store write port: identity fill or one half of a swap
   always_comb begin
      wr_en   = cmd.fill || cmd.write_n || cmd.write_i;
      wr_addr = idx_ff;
      wr_data = idx_ff;
      if (cmd.write_n) begin
         wr_addr = swap_idx;
         wr_data = rd_i_ff;
      end else if (cmd.write_i) begin
         wr_data = rd_n_ff;
      end
   end

   // store with one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.swap_read || cmd.out_read) begin
         rd_n_ff <= mem[swap_idx];
         rd_i_ff <= mem[idx_ff];
      end
   end

   assign status.count_zero = (count_sat == '0);
   assign status.idx_last   = idx_last;
   assign status.div_busy   = div_busy;

   assign position    = FIELD_W'(idx_ff);
   assign entry_value = FIELD_W'(rd_i_ff);

endmodule
`default_nettype wire

[hdl/xps_ctrl.sv]
// sequencer for fill, swap pass and output of the shuffler
`default_nettype none
module xps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire xps_pkg::xps_status_type status,
   output xps_pkg::xps_cmd_type         cmd
);
   import xps_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_ADVANCE,
      ST_DIVIDE,
      ST_READ,
      ST_WRITE_N,
      ST_WRITE_I,
      ST_OUT_READ,
      ST_OUT_VALID
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = status.count_zero ? ST_IDLE : ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.idx_last) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.swap_read = 1'b1;
            state_in      = ST_WRITE_N;
         end
         ST_WRITE_N: begin
            cmd.write_n = 1'b1;
            state_in    = ST_WRITE_I;
         end
         ST_WRITE_I: begin
            cmd.write_i = 1'b1;
            state_in    = status.idx_last ? ST_OUT_READ : ST_ADVANCE;
         end
         ST_OUT_READ: begin
            cmd.out_read = 1'b1;
            state_in     = ST_OUT_VALID;
         end
         ST_OUT_VALID: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.out_next = 1'b1;
               state_in     = status.idx_last ? ST_IDLE : ST_OUT_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hdl/xorshift_playlist_shuffle.sv]
// top level of the xorshift playlist shuffler
//
// channel  direction  signals                        word
// req      in         req_tvalid/tready/tdata        seed
// rsp      out        rsp_tvalid/tready/tdata/tlast  position, entry_value, last
// csr      in         csr_valid/ready/data           entry_count
//
// a seed is handled as a fill with one store write per entry, then per entry
// one generator step, a wait on the remainder unit, one read and two writes on
// the single store write port, then one output word per entry, which a
// receiver stall can hold. a zero count returns at once.
// synchronous reset clears the sequencer and sets entry_count to 64; the store
// is not cleared. one seed is handled at a time: req_tready is high only idle.
`default_nettype none
module xorshift_playlist_shuffle (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [xps_pkg::SEED_W-1:0] req_tdata,  // [15:0] seed
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [xps_pkg::RSP_W-1:0]       rsp_tdata,  // [5:0] position, [11:6] entry_value
   output logic                            rsp_tlast,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [xps_pkg::CSR_W-1:0]  csr_data    // entry_count
);
   import xps_pkg::*;

   xps_cmd_type        cmd;
   xps_status_type     status;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] entry_value;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   xps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // store, generator and counters
   xps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_write   (csr_valid && csr_ready),
      .csr_value   (csr_data),
      .seed        (req_tdata),
      .position    (position),
      .entry_value (entry_value)
   );

   // output word packing
   assign rsp_tdata = {(RSP_W - 2 * FIELD_W)'(0), entry_value, position};
   assign rsp_tlast = status.idx_last;

endmodule
`default_nettype wire

[tb/sv/xorshift_playlist_shuffle_test.sv]
// self-checking testbench for the xorshift playlist shuffler
`timescale 1ns / 1ps

module xorshift_playlist_shuffle_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int TAIL_CYCLES    = 2000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int RANDOM_ITEMS   = 430;

   // one expected result word
   typedef struct {
      logic [xps_pkg::FIELD_W-1:0] position;
      logic [xps_pkg::FIELD_W-1:0] entry_value;
      logic                        is_last;
   } shuffle_word_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [xps_pkg::SEED_W-1:0]   req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [xps_pkg::RSP_W-1:0]    rsp_tdata;
   logic                         rsp_tlast;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [xps_pkg::CSR_W-1:0]    csr_data = '0;

   logic [xps_pkg::SEED_W-1:0]   seed_queue[$];
   shuffle_word_type             expected_words[$];
   logic [xps_pkg::CSR_W-1:0]    count_setting = 7'd64;

   int seeds_total    = 0;
   int seeds_accepted = 0;
   int words_seen     = 0;
   int settings_done  = 0;
   int errors         = 0;

   xorshift_playlist_shuffle dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] seed
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [5:0] position, [11:6] entry_value
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // entry_count
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // one generator step: shift left, right, left, wrapping at 16 bits
   function automatic logic [15:0] xs_next(input logic [15:0] x);
      logic [15:0] y;
      y = x ^ {x[10:0], 5'b0};
      y = y ^ {9'b0, y[15:9]};
      y = y ^ {y[13:0], 2'b0};
      return y;
   endfunction

   // identity fill, naive swap pass, then one word per entry
   task automatic predict_shuffle(input logic [15:0] seed);
      logic [5:0]       perm[0:63];
      logic [5:0]       t;
      logic [15:0]      x;
      int               cnt;
      int               n;
      shuffle_word_type w;
      cnt = (count_setting > 7'd64) ? 64 : int'(count_setting);
      x = seed;
      for (int i = 0; i < cnt; i++) perm[i] = 6'(i);
      for (int i = 0; i < cnt; i++) begin
         x = xs_next(x);
         n = int'(x) % cnt;
         t = perm[n];
         perm[n] = perm[i];
         perm[i] = t;
      end
      for (int i = 0; i < cnt; i++) begin
         w.position    = 6'(i);
         w.entry_value = perm[i];
         w.is_last     = (i == cnt - 1);
         expected_words.push_back(w);
      end
   endtask

   // sender: bursts of seeds with random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_shuffle(req_tdata);
            seeds_accepted++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered word
         end else if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (seed_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= seed_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 6);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern that changes mode, plus one long hold
   int  rx_cycle  = 0;
   int  rx_mode   = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
      if (!hold_done && words_seen >= 150) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= (rx_cycle % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      shuffle_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata[5:0] !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_tdata[5:0]);
               errors++;
            end
            if (rsp_tdata[11:6] !== want.entry_value) begin
               $error("entry_value: expected %0d, actual %0d", want.entry_value,
                      rsp_tdata[11:6]);
               errors++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last: expected %0b, actual %0b", want.is_last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic add_seed(input logic [15:0] s);
      seed_queue.push_back(s);
      seeds_total++;
   endtask

   task automatic wait_drained();
      while (seeds_accepted != seeds_total || expected_words.size() != 0) @(posedge clock);
   endtask

   // write entry_count once the block has gone idle
   task automatic set_count(input logic [6:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_setting = v;
      settings_done++;
   endtask

   // stimulus
   initial begin
      int random_items;
      int cnt;
      int n_items;
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and special seeds at full size
      set_count(7'd64);
      add_seed(16'h0000);
      add_seed(16'hFFFF);
      add_seed(16'h0001);
      add_seed(16'h8000);
      add_seed(16'h5555);
      add_seed(16'hAAAA);
      // single entry, then two entries
      set_count(7'd1);
      add_seed(16'h0000);
      add_seed(16'hFFFF);
      set_count(7'd2);
      add_seed(16'h1234);
      add_seed(16'h0000);
      // zero count gives no words
      set_count(7'd0);
      add_seed(16'h0000);
      add_seed(16'hFFFF);
      add_seed(16'h0007);
      // counts above the store depth saturate, then three entries
      set_count(7'd65);
      add_seed(16'h0009);
      set_count(7'd127);
      add_seed(16'hBEEF);
      set_count(7'd3);
      add_seed(16'h0001);
      add_seed(16'h0002);
      add_seed(16'h0003);

      // random phases, mostly small counts
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) cnt = 0;
         else if (pick == 1) cnt = $urandom_range(64, 127);
         else if (pick == 2) cnt = 1;
         else cnt = $urandom_range(2, 16);
         if (cnt > 32) n_items = 4;
         else if (cnt == 0) n_items = 6;
         else n_items = $urandom_range(15, 30);
         set_count(7'(cnt));
         for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) == 0)
               add_seed($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            else
               add_seed(16'($urandom_range(0, 65535)));
         end
         if (cnt != 0) random_items += n_items;
      end

      // drain and watch for stray words
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         errors++;
      end

      $display("covered %0d seeds under %0d entry_count settings (0, 1, 64 and saturating)",
               seeds_total, settings_done);
      $display("checked %0d result words, %0d mismatches", words_seen, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
